// ===== rtl/bpd_pkg.sv =====
// Shared constants and register codes for the 2x2 block pooling downsampler.
package bpd_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int MAX_WIDTH  = 4096;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS = COL_BITS + 1;
  localparam int ROW_BITS   = 16;
  localparam int SUM_BITS   = PIXEL_BITS + 2;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_METHOD        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMG_WIDTH     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMG_HEIGHT    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXELS_SIGNED = 2'd3;

  // Reduction methods
  localparam logic [1:0] METHOD_TOP_LEFT = 2'd0;
  localparam logic [1:0] METHOD_MEAN     = 2'd1;
  localparam logic [1:0] METHOD_MIN      = 2'd2;
  localparam logic [1:0] METHOD_MAX      = 2'd3;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = ROW_BITS'(1024);

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // Position flags carried with a pixel in the input stage
  typedef struct packed {
    logic odd_row;
    logic odd_col;
    logic last_col;
    logic last_row;
  } pos_t;

endpackage

// ===== rtl/bpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/block_pool_downsample_2x2.sv =====
// Top level of the 2x2 block pooling downsampler.
//
//   port group   | dir | beat contents
//   -------------+-----+--------------------------------------------
//   s_t*         | in  | one pixel, row-major order
//   m_t*         | out | one reduced pixel per 2x2 block, tlast at frame end
//   cfg_*        | in  | register write: method, width, height, signedness
//
// One pixel beat per cycle unless an output stall holds the input stage; a beat
// passes the input stage, with the line store read, then the result register.
// The line store is written on even rows and read at every beat, used on odd rows.
// Reset clears counters, configuration, left pixel and valid flags; the line
// store is left as is, since every entry read is written on the even row before.
// An output stall holds the input stage only while that stage holds a block result.
module block_pool_downsample_2x2 (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [15:0]                          s_tdata,   // [15:0] pixel_in
  // Output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [15:0]                          m_tdata,   // [15:0] pixel_out
  output logic                                 m_tlast,   // frame_last
  // Configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [bpd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bpd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // Configuration registers
  logic [1:0]                       method;
  logic [bpd_pkg::WIDTH_BITS-1:0]   img_width;
  logic [bpd_pkg::ROW_BITS-1:0]     img_height;
  logic                             pixels_signed;

  // Position counters
  logic [bpd_pkg::COL_BITS-1:0]     col_count;
  logic [bpd_pkg::ROW_BITS-1:0]     row_count;

  // Input stage
  logic                             s1_valid;
  bpd_pkg::pixel_t                  s1_pixel;
  bpd_pkg::pos_t                    s1_pos;

  // Block neighbours
  bpd_pkg::pixel_t                  left_pixel;
  bpd_pkg::pixel_t                  up_left;
  bpd_pkg::pixel_t                  up_pixel;

  logic [bpd_pkg::WIDTH_BITS-1:0]   width_m1;
  logic [bpd_pkg::ROW_BITS-1:0]     height_m1;
  logic                             in_beat;
  logic                             s1_adv;
  logic                             s1_emit;
  bpd_pkg::pos_t                    pos_next;
  bpd_pkg::pixel_t                  blk_a, blk_b, blk_c, blk_d;
  bpd_pkg::pixel_t                  result;

  // Map to an order-preserving unsigned code
  function automatic bpd_pkg::pixel_t to_key(input bpd_pkg::pixel_t v, input logic sgn);
    to_key = {v[bpd_pkg::PIXEL_BITS-1] ^ sgn, v[bpd_pkg::PIXEL_BITS-2:0]};
  endfunction

  function automatic bpd_pkg::pixel_t pick(input bpd_pkg::pixel_t x, input bpd_pkg::pixel_t y,
                                           input logic sgn, input logic want_max);
    logic x_less;
    x_less = to_key(x, sgn) < to_key(y, sgn);
    if (want_max) begin
      pick = x_less ? y : x;
    end else begin
      pick = x_less ? x : y;
    end
  endfunction

  function automatic bpd_pkg::pixel_t mean4(input bpd_pkg::pixel_t a, input bpd_pkg::pixel_t b,
                                            input bpd_pkg::pixel_t c, input bpd_pkg::pixel_t d,
                                            input logic sgn);
    logic [bpd_pkg::SUM_BITS-1:0] sum;
    bpd_pkg::pixel_t              res;
    sum = bpd_pkg::SUM_BITS'(to_key(a, sgn)) + bpd_pkg::SUM_BITS'(to_key(b, sgn))
        + bpd_pkg::SUM_BITS'(to_key(c, sgn)) + bpd_pkg::SUM_BITS'(to_key(d, sgn));
    res = to_key(sum[bpd_pkg::SUM_BITS-1:2], sgn);
    // Round a negative inexact quotient toward zero
    if (sgn && res[bpd_pkg::PIXEL_BITS-1] && (sum[1:0] != 2'b00)) begin
      res = res + bpd_pkg::PIXEL_BITS'(1);
    end
    mean4 = res;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      method        <= bpd_pkg::METHOD_TOP_LEFT;
      img_width     <= bpd_pkg::WIDTH_RESET;
      img_height    <= bpd_pkg::HEIGHT_RESET;
      pixels_signed <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bpd_pkg::REG_METHOD:        method        <= cfg_data[1:0];
        bpd_pkg::REG_IMG_WIDTH:     img_width     <= cfg_data[bpd_pkg::WIDTH_BITS-1:0];
        bpd_pkg::REG_IMG_HEIGHT:    img_height    <= cfg_data[bpd_pkg::ROW_BITS-1:0];
        bpd_pkg::REG_PIXELS_SIGNED: pixels_signed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    if (img_width == '0) begin
      width_m1 = '0;
    end else if (img_width > bpd_pkg::WIDTH_RESET) begin
      width_m1 = bpd_pkg::WIDTH_RESET - bpd_pkg::WIDTH_BITS'(1);
    end else begin
      width_m1 = img_width - bpd_pkg::WIDTH_BITS'(1);
    end
    height_m1 = (img_height == '0) ? '0 : img_height - bpd_pkg::ROW_BITS'(1);
  end

  // Position of the incoming pixel
  always_comb begin
    pos_next.odd_row  = row_count[0];
    pos_next.odd_col  = col_count[0];
    pos_next.last_col = {1'b0, col_count} >= width_m1;
    pos_next.last_row = row_count >= height_m1;
  end

  // Handshake between the stages
  assign s1_emit  = s1_pos.odd_row ? (s1_pos.odd_col || s1_pos.last_col)
                                   : (s1_pos.last_row && (s1_pos.odd_col || s1_pos.last_col));
  assign s1_adv   = s1_valid && (!s1_emit || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign in_beat  = s_tvalid && s_tready;

  // Advance the row and column counters on each input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_beat) begin
      if (pos_next.last_col) begin
        col_count <= '0;
        row_count <= pos_next.last_row ? '0 : row_count + bpd_pkg::ROW_BITS'(1);
      end else begin
        col_count <= col_count + bpd_pkg::COL_BITS'(1);
      end
    end
  end

  // Line store: write the even row, read the pixel above on the odd row
  bpd_ram #(
    .WIDTH (bpd_pkg::PIXEL_BITS),
    .DEPTH (bpd_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (in_beat && !row_count[0]),
    .wr_addr (col_count),
    .wr_data (s_tdata),
    .rd_en   (in_beat),
    .rd_addr (col_count),
    .rd_data (up_pixel)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_pixel <= s_tdata;
      s1_pos   <= pos_next;
    end
  end

  // Hold the even-column neighbours for the next pixel of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= '0;
    end else if (s1_adv && !s1_pos.odd_col) begin
      left_pixel <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_pos.odd_col) begin
      up_left <= up_pixel;
    end
  end

  // Pick the four block pixels, repeating edges where a neighbour is missing
  always_comb begin
    if (s1_pos.odd_row) begin
      if (s1_pos.odd_col) begin
        blk_a = up_left;
        blk_b = up_pixel;
        blk_c = left_pixel;
      end else begin
        blk_a = up_pixel;
        blk_b = up_pixel;
        blk_c = s1_pixel;
      end
    end else begin
      if (s1_pos.odd_col) begin
        blk_a = left_pixel;
        blk_b = s1_pixel;
        blk_c = left_pixel;
      end else begin
        blk_a = s1_pixel;
        blk_b = s1_pixel;
        blk_c = s1_pixel;
      end
    end
    blk_d = s1_pixel;
  end

  // Reduce the block
  always_comb begin
    case (method)
      bpd_pkg::METHOD_MEAN:
        result = mean4(blk_a, blk_b, blk_c, blk_d, pixels_signed);
      bpd_pkg::METHOD_MIN:
        result = pick(pick(pick(blk_a, blk_b, pixels_signed, 1'b0),
                           blk_c, pixels_signed, 1'b0), blk_d, pixels_signed, 1'b0);
      bpd_pkg::METHOD_MAX:
        result = pick(pick(pick(blk_a, blk_b, pixels_signed, 1'b1),
                           blk_c, pixels_signed, 1'b1), blk_d, pixels_signed, 1'b1);
      default:
        result = blk_a;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      m_tdata <= result;
      m_tlast <= s1_pos.last_col && s1_pos.last_row;
    end
  end

  // Checks
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_beat && pos_next.last_col) |=> (col_count == '0))
    else $error("column count did not wrap at row end");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !pos_next.last_col) |=>
      (col_count == $past(col_count) + bpd_pkg::COL_BITS'(1)))
    else $error("column count did not step by one");

  a_block_out: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_pos.odd_row && s1_pos.odd_col) |=> m_tvalid)
    else $error("completed block gave no output beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/block_pool_downsample_2x2_tb.sv =====
// Self-checking testbench for the 2x2 block pooling downsampler.
module block_pool_downsample_2x2_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    bpd_pkg::pixel_t pix;
    logic            last;
  } pooled_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [15:0]                        s_tdata = '0;    // [15:0] pixel_in
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [15:0]                        m_tdata;         // [15:0] pixel_out
  logic                               m_tlast;         // frame_last
  logic                               cfg_wr_en = 1'b0;
  logic [bpd_pkg::CFG_INDEX_BITS-1:0] cfg_index = bpd_pkg::REG_METHOD;
  logic [bpd_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Shadow of the block: configuration, counters and line store
  logic [1:0]      sh_method = bpd_pkg::METHOD_TOP_LEFT;
  logic [12:0]     sh_width = 13'd4096;
  logic [15:0]     sh_height = 16'd1024;
  logic            sh_signed = 1'b0;
  bpd_pkg::pixel_t line_mem [bpd_pkg::MAX_WIDTH];
  bpd_pkg::pixel_t left_px = '0;
  int unsigned     row_pos = 0;
  int unsigned     col_pos = 0;

  pooled_t     pending_pooled [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;

  block_pool_downsample_2x2 DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10ns clk = ~clk;

  // Stall the output at random unless a steady stretch is running
  always @(posedge clk) begin
    m_tready <= !idle_on || ($urandom_range(99) >= 38);
  end

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Ordering in the block's signed or unsigned sense
  function automatic bit is_below(bpd_pkg::pixel_t x, bpd_pkg::pixel_t y);
    if (sh_signed)
      return $signed(x) < $signed(y);
    return x < y;
  endfunction

  function automatic bpd_pkg::pixel_t reduce_block(bpd_pkg::pixel_t a, bpd_pkg::pixel_t b,
                                                   bpd_pkg::pixel_t c, bpd_pkg::pixel_t d);
    int              sum;
    bpd_pkg::pixel_t m;
    case (sh_method)
      bpd_pkg::METHOD_MEAN: begin
        // widened sum; integer division truncates toward zero
        if (sh_signed)
          sum = (int'($signed(a)) + int'($signed(b)) + int'($signed(c))
                 + int'($signed(d))) / 4;
        else
          sum = (int'(a) + int'(b) + int'(c) + int'(d)) / 4;
        return bpd_pkg::pixel_t'(sum);
      end
      bpd_pkg::METHOD_MIN: begin
        m = a;
        if (is_below(b, m)) m = b;
        if (is_below(c, m)) m = c;
        if (is_below(d, m)) m = d;
        return m;
      end
      bpd_pkg::METHOD_MAX: begin
        m = a;
        if (is_below(m, b)) m = b;
        if (is_below(m, c)) m = c;
        if (is_below(m, d)) m = d;
        return m;
      end
      default: return a;
    endcase
  endfunction

  // Advance the shadow by one pixel and queue the pooled value it completes
  function automatic void predict_downsample(bpd_pkg::pixel_t px);
    int unsigned     w, h, col, row;
    bit              last_col, last_row, odd_col, odd_row, emit;
    bpd_pkg::pixel_t val, up;
    w = sh_width;
    if (w < 1) w = 1;
    if (w > bpd_pkg::MAX_WIDTH) w = bpd_pkg::MAX_WIDTH;
    h = (sh_height == 0) ? 1 : sh_height;
    col = col_pos;
    row = row_pos;
    last_col = col >= w - 1;
    last_row = row >= h - 1;
    odd_col = col[0];
    odd_row = row[0];
    emit = 1'b0;
    val = '0;
    if (!odd_row) begin
      line_mem[col] = px;
      // odd height: the lower row repeats this one
      if (last_row) begin
        if (odd_col) begin
          val = reduce_block(left_px, px, left_px, px);
          emit = 1'b1;
        end else if (last_col) begin
          val = reduce_block(px, px, px, px);
          emit = 1'b1;
        end
      end
    end else begin
      if (odd_col) begin
        val = reduce_block(line_mem[col - 1], line_mem[col], left_px, px);
        emit = 1'b1;
      end else if (last_col) begin
        up = line_mem[col];
        val = reduce_block(up, up, px, px);
        emit = 1'b1;
      end
    end
    if (!odd_col) left_px = px;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    if (emit) pending_pooled.push_back('{pix: val, last: last_col && last_row});
  endfunction

  // Compare each output beat with the oldest pooled value
  always @(negedge clk) begin
    pooled_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pooled.size() == 0) begin
        $error("pixel_out: no block pending, got %h (tlast %b)", m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        want = pending_pooled.pop_front();
        if (m_tdata !== want.pix) begin
          $error("pixel_out: expected %h, got %h", want.pix, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $error("frame_last: expected %b, got %b", want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  function automatic bpd_pkg::pixel_t random_pixel();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(5))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'h8000;
        3: return 16'h7FFF;
        4: return 16'h0001;
        default: return 16'hFFFE;
      endcase
    end
    return bpd_pkg::pixel_t'($urandom);
  endfunction

  // Send one pixel beat, idling at random first; returns at the accepting edge
  task automatic send_pixel(input bpd_pkg::pixel_t px);
    while (idle_on && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predict_downsample(px);
  endtask

  // Hold the input until every pooled value is out and the pipeline is empty
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_pooled.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one register; the enable stays high until end_writes
  task automatic set_reg(input logic [bpd_pkg::CFG_INDEX_BITS-1:0] idx,
                         input logic [bpd_pkg::CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      bpd_pkg::REG_METHOD:        sh_method = data[1:0];
      bpd_pkg::REG_IMG_WIDTH:     sh_width  = data[12:0];
      bpd_pkg::REG_IMG_HEIGHT:    sh_height = data;
      bpd_pkg::REG_PIXELS_SIGNED: sh_signed = data[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] method, input logic [15:0] width,
                           input logic [15:0] height, input logic is_signed);
    set_reg(bpd_pkg::REG_METHOD, 16'(method));
    set_reg(bpd_pkg::REG_IMG_WIDTH, width);
    set_reg(bpd_pkg::REG_IMG_HEIGHT, height);
    set_reg(bpd_pkg::REG_PIXELS_SIGNED, 16'(is_signed));
    end_writes();
  endtask

  // Odd width and height with full-scale values: edge repeat and wide mean sum
  task automatic test_odd_frame_mean();
    bpd_pkg::pixel_t pix [9] = '{16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFE,
                                 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF};
    configure(bpd_pkg::METHOD_MEAN, 16'd3, 16'd3, 1'b0);
    foreach (pix[i]) send_pixel(pix[i]);
    drain_pipeline();
  endtask

  // Signed mean rounds toward zero, including the most negative values
  task automatic test_signed_mean();
    bpd_pkg::pixel_t pix [8] = '{16'hFFFF, 16'hFFFE, 16'h8000, 16'h8000,
                                 16'h0000, 16'h0000, 16'h8000, 16'h8001};
    configure(bpd_pkg::METHOD_MEAN, 16'd4, 16'd2, 1'b1);
    foreach (pix[i]) send_pixel(pix[i]);
    drain_pipeline();
  endtask

  // Signed minimum, unsigned maximum and top-left on a single two-pixel row
  task automatic test_compare_methods();
    configure(bpd_pkg::METHOD_MIN, 16'd2, 16'd1, 1'b1);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    drain_pipeline();
    configure(bpd_pkg::METHOD_MAX, 16'd2, 16'd1, 1'b0);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    drain_pipeline();
    configure(bpd_pkg::METHOD_TOP_LEFT, 16'd2, 16'd1, 1'b0);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    drain_pipeline();
  endtask

  // Widths above the maximum and zero height: a long row that does not end early,
  // then closed by shrinking the width
  task automatic test_wide_clamp();
    configure(bpd_pkg::METHOD_MAX, 16'h1001, 16'h0000, 1'b1);
    repeat (150) send_pixel(random_pixel());
    drain_pipeline();
    set_reg(bpd_pkg::REG_IMG_WIDTH, 16'd2);
    end_writes();
    send_pixel(random_pixel());
    drain_pipeline();
    configure(bpd_pkg::METHOD_MIN, 16'h1FFF, 16'h0000, 1'b0);
    repeat (130) send_pixel(random_pixel());
    drain_pipeline();
    set_reg(bpd_pkg::REG_IMG_WIDTH, 16'd2);
    end_writes();
    send_pixel(random_pixel());
    drain_pipeline();
  endtask

  // Shrink height and width while a frame is open; the open row closes at once
  task automatic test_inframe_changes();
    configure(bpd_pkg::METHOD_MIN, 16'd1, 16'hFFFF, 1'b0);
    repeat (11) send_pixel(random_pixel());
    drain_pipeline();
    set_reg(bpd_pkg::REG_IMG_HEIGHT, 16'd4);
    end_writes();
    send_pixel(random_pixel());
    drain_pipeline();
    configure(bpd_pkg::METHOD_MEAN, 16'd4096, 16'd2, 1'b1);
    repeat (30) send_pixel(random_pixel());
    drain_pipeline();
    set_reg(bpd_pkg::REG_IMG_WIDTH, 16'd7);
    end_writes();
    repeat (8) send_pixel(random_pixel());
    drain_pipeline();
  endtask

  // Whole frames under random settings, small sizes mostly
  task automatic test_random_frames();
    int unsigned sent, phase, w, h, eff_w, eff_h, frames;
    sent = 0;
    phase = 0;
    while (sent < 1300) begin
      idle_on = !(phase >= 4 && phase < 9);
      if ($urandom_range(19) == 0)
        w = 0;
      else
        w = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 80);
      if ($urandom_range(19) == 0)
        h = 0;
      else
        h = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
      eff_w = (w == 0) ? 1 : w;
      eff_h = (h == 0) ? 1 : h;
      configure(2'($urandom_range(3)), 16'(w), 16'(h), 1'($urandom_range(1)));
      frames = $urandom_range(1, 2);
      repeat (frames * eff_w * eff_h) begin
        send_pixel(random_pixel());
        sent++;
        if ($urandom_range(199) == 0) drain_pipeline();
      end
      drain_pipeline();
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_odd_frame_mean();
    test_signed_mean();
    test_compare_methods();
    test_inframe_changes();
    test_wide_clamp();
    test_random_frames();
    drain_pipeline();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
